/* rtl/spmq_pkg.sv */
package spmq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int OCC_W        = 5;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [15:0]        tag_in;
    logic [7:0]         age_in;
    logic signed [15:0] priority_in;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        tag_out;
    logic [7:0]         age_out;
    logic signed [15:0] priority_out;
    logic [OCC_W-1:0]   occupancy;
  } out_t;

  typedef struct packed {
    logic [15:0]        tag;
    logic [7:0]         age;
    logic signed [15:0] prio;
  } entry_t;

  // broadcast from the queue control to every cell
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t ent;
  } cell_ctl_t;

endpackage

/* rtl/spmq_cell.sv */
module spmq_cell (
  input  logic               clk,
  input  spmq_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  logic               left_gb,
  input  spmq_pkg::entry_t   left_ent,
  input  spmq_pkg::entry_t   right_ent,
  output logic               gb,
  output spmq_pkg::entry_t   ent
);
  import spmq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // new entry goes ahead of this one: empty slot or strictly higher priority
  assign gb  = !valid || (ctl.ent.prio > ent_r.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins && gb) begin
      ent_nxt = left_gb ? left_ent : ctl.ent;
    end else if (ctl.del) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

/* rtl/stable_max_priority_queue.sv */
// channel  | ports                    | handshake
// ---------+--------------------------+-----------------------------------------
// input    | start, busy, in_item     | item taken on clk edge with start & !busy
// result   | out_strobe, out_item     | one cycle per result, no back-pressure
//
// the edge that takes an item loads the command register; in the cycle after,
// the cell row updates and the result is registered
// busy is high for a single cycle in between, so a new start can
// be taken in the same cycle the previous result is on out_item
// rst_n (synchronous) empties the queue; cell contents are not cleared
// the receiver cannot stall; every item gives exactly one result
module stable_max_priority_queue #(
  parameter int CAPACITY = spmq_pkg::DEF_CAPACITY
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  spmq_pkg::in_t  in_item,
  output logic           out_strobe,
  output spmq_pkg::out_t out_item
);
  import spmq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // command register
  logic pend_r;
  in_t  cmd_r;

  // entry count, broadcast to the cells as per-slot valid
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  // result register
  logic out_strobe_r;
  out_t out_r;
  out_t out_nxt;

  cell_ctl_t ctl;

  // row of cells, kept sorted by priority descending, arrival order on ties,
  // so the head cell always holds the entry to dequeue
  logic   [CAPACITY-1:0] gb;
  entry_t                cell_ent [CAPACITY];

  logic [CW+OCC_W-1:0] occ_wide;

  assign busy       = pend_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  always_comb begin
    cnt_nxt         = cnt_r;
    ctl.ins         = 1'b0;
    ctl.del         = 1'b0;
    ctl.ent.tag     = cmd_r.tag_in;
    ctl.ent.age     = cmd_r.age_in;
    ctl.ent.prio    = cmd_r.priority_in;
    out_nxt         = '0;
    if (cmd_r.mode == MODE_ENQ) begin
      if (cnt_r >= CW'(CAPACITY)) begin
        out_nxt.status = ST_FULL;
      end else begin
        ctl.ins        = pend_r;
        cnt_nxt        = cnt_r + 1'b1;
        out_nxt.status = ST_ENQUEUED;
      end
    end else begin
      if (cnt_r == '0) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        ctl.del              = pend_r;
        cnt_nxt              = cnt_r - 1'b1;
        out_nxt.status       = ST_DEQUEUED;
        out_nxt.tag_out      = cell_ent[0].tag;
        out_nxt.age_out      = cell_ent[0].age;
        out_nxt.priority_out = cell_ent[0].prio;
      end
    end
    // occupancy is the count masked to the field width
    occ_wide          = (CW + OCC_W)'(cnt_nxt);
    out_nxt.occupancy = occ_wide[OCC_W-1:0];
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic   lgb;
      entry_t lent;
      entry_t rent;
      if (i == 0) begin : g_head
        assign lgb  = 1'b0;
        assign lent = cell_ent[0];
      end else begin : g_mid
        assign lgb  = gb[i-1];
        assign lent = cell_ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign rent = cell_ent[i];
      end else begin : g_body
        assign rent = cell_ent[i+1];
      end
      spmq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (CW'(i) < cnt_r),
        .left_gb   (lgb),
        .left_ent  (lent),
        .right_ent (rent),
        .gb        (gb[i]),
        .ent       (cell_ent[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= 1'b0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pend_r;
      if (pend_r) begin
        pend_r <= 1'b0;
        cnt_r  <= cnt_nxt;
      end else if (start) begin
        pend_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !pend_r) begin
      cmd_r <= in_item;
    end
    if (pend_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/spmq_checker.sv */
module spmq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input spmq_pkg::out_t out_item
);
  import spmq_pkg::*;

  // taking an item raises busy and no result shows in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_strobe)
    else $error("accepted item did not raise busy");

  // busy lasts one cycle and ends with a result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_strobe)
    else $error("busy did not end with a result");

  // results never come on back-to-back cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on back-to-back cycles");

  // fields are zero unless an entry was removed
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != ST_DEQUEUED |->
      out_item.tag_out == '0 && out_item.age_out == '0 && out_item.priority_out == '0)
    else $error("nonzero fields on a result without an entry");

  // an empty report always shows zero occupancy
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status == ST_EMPTY |-> out_item.occupancy == '0)
    else $error("empty status with nonzero occupancy");

endmodule

bind stable_max_priority_queue spmq_checker u_spmq_checker (.*);

/* dv/stable_max_priority_queue_test.sv */
`timescale 1ns / 100ps

module stable_max_priority_queue_test;
  import spmq_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_ITEMS  = 150;      // tail of the run with no input gaps
  localparam int CYCLE_LIMIT  = 100000;
  localparam int MAX_PRINTED  = 40;

  // one row of the directed table; reps > 1 repeats the item with the tag stepped
  typedef struct {
    in_t  item;
    int   reps;
    bit   pinned;   // result typed into the table instead of predicted
    out_t result;
  } drill_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic start     = 1'b0;
  in_t  in_item   = '0;
  logic busy;
  logic out_strobe;
  out_t out_item;

  // pinned expectation travels with the item so the monitor sees it at acceptance
  logic pin_valid  = 1'b0;
  out_t pin_result = '0;

  // predictor state: entries in arrival order, oldest at index 0
  entry_t model_entries [CAP];
  int     model_count = 0;

  out_t       pending_results [$];
  drill_row_t drill_rows [$];

  int  cycle_count = 0;
  int  mismatches  = 0;
  int  items_taken = 0;
  int  n_enqueued = 0, n_dequeued = 0, n_empty = 0, n_full = 0;
  bit  gaps_on = 1'b1;

  stable_max_priority_queue #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // expected result of one item; updates the predictor's copy of the queue
  function automatic out_t predict_queue_result(in_t it);
    out_t r;
    int   best;
    int   i;
    r = '0;
    if (it.mode == MODE_ENQ) begin
      if (model_count >= CAP) begin
        // full: item is dropped, payload fields stay zero
        r.status = ST_FULL;
      end else begin
        model_entries[model_count] = {it.tag_in, it.age_in, it.priority_in};
        model_count++;
        r.status = ST_ENQUEUED;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // strict greater-than keeps the oldest entry among equal priorities
      best = 0;
      for (i = 1; i < model_count; i++)
        if (model_entries[i].prio > model_entries[best].prio)
          best = i;
      r.status       = ST_DEQUEUED;
      r.tag_out      = model_entries[best].tag;
      r.age_out      = model_entries[best].age;
      r.priority_out = model_entries[best].prio;
      // close the gap, arrival order kept
      for (i = best; i + 1 < model_count; i++)
        model_entries[i] = model_entries[i + 1];
      model_count--;
    end
    r.occupancy = model_count[OCC_W-1:0];
    return r;
  endfunction

  // monitor: results are checked before the item taken at the same edge is
  // predicted, so a result can never match its own item's expectation early
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (status %0d)",
                                    out_item.status));
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_item.status, want.status));
          if (out_item.tag_out !== want.tag_out)
            report_mismatch($sformatf("tag_out got %h want %h",
                                      out_item.tag_out, want.tag_out));
          if (out_item.age_out !== want.age_out)
            report_mismatch($sformatf("age_out got %h want %h",
                                      out_item.age_out, want.age_out));
          if (out_item.priority_out !== want.priority_out)
            report_mismatch($sformatf("priority_out got %h want %h",
                                      out_item.priority_out, want.priority_out));
          if (out_item.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      out_item.occupancy, want.occupancy));
        end
      end
      if (start && !busy) begin
        // the predictor always runs so its state tracks the block
        want = predict_queue_result(in_item);
        if (pin_valid)
          want = pin_result;
        pending_results.push_back(want);
        items_taken++;
        case (want.status)
          ST_ENQUEUED: n_enqueued++;
          ST_DEQUEUED: n_dequeued++;
          ST_EMPTY:    n_empty++;
          default:     n_full++;
        endcase
      end
    end
  end

  // present one item and hold it until taken; start stays high into the next
  // item unless a gap follows, so start never sees two assignments in one step
  task automatic send_item(in_t it, bit pinned, out_t result);
    int gap;
    start      <= 1'b1;
    in_item    <= it;
    pin_valid  <= pinned;
    pin_result <= result;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      // the cycle right after a take is busy anyway, so idle starts after it
      repeat (gap + 1) @(posedge clk);
    end
  endtask

  task automatic add_row(in_t item, int reps, bit pinned, out_t result);
    drill_row_t row;
    row.item   = item;
    row.reps   = reps;
    row.pinned = pinned;
    row.result = result;
    drill_rows.push_back(row);
  endtask

  initial begin
    in_t  it;
    int   k;
    int   n;
    int   enq_pct;
    int   occ_tie;

    // directed table; fields of enqueue rows are {mode, tag, age, priority}
    // dequeue on empty right after reset
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b1,
            {ST_EMPTY, 16'h0000, 8'h00, 16'h0000, 5'd0});
    // extremes in, extremes out
    add_row({MODE_ENQ, 16'hffff, 8'hff, 16'h7fff}, 1, 1'b1,
            {ST_ENQUEUED, 16'h0000, 8'h00, 16'h0000, 5'd1});
    add_row({MODE_ENQ, 16'h0000, 8'h00, 16'h8000}, 1, 1'b1,
            {ST_ENQUEUED, 16'h0000, 8'h00, 16'h0000, 5'd2});
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b1,
            {ST_DEQUEUED, 16'hffff, 8'hff, 16'h7fff, 5'd1});
    add_row({MODE_DEQ, 16'hffff, 8'hff, 16'hffff}, 1, 1'b1,
            {ST_DEQUEUED, 16'h0000, 8'h00, 16'h8000, 5'd0});
    add_row({MODE_DEQ, 16'h1234, 8'h56, 16'h789a}, 1, 1'b1,
            {ST_EMPTY, 16'h0000, 8'h00, 16'h0000, 5'd0});
    // ties: oldest of equal priorities must leave first, -1 stays behind
    add_row({MODE_ENQ, 16'h0011, 8'h10, 16'h0005}, 1, 1'b0, '0);
    add_row({MODE_ENQ, 16'h0022, 8'h20, 16'h0005}, 1, 1'b0, '0);
    add_row({MODE_ENQ, 16'h0033, 8'h30, 16'hffff}, 1, 1'b0, '0);
    add_row({MODE_ENQ, 16'h0044, 8'h40, 16'h0005}, 1, 1'b0, '0);
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b0, '0);
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b0, '0);
    // zero priority sits between -1 and 5
    add_row({MODE_ENQ, 16'h5a5a, 8'ha5, 16'h0000}, 1, 1'b0, '0);
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b0, '0);
    // fill to capacity with equal lowest priorities, then overflow
    add_row({MODE_ENQ, 16'h0100, 8'h55, 16'h8000}, CAP - 2, 1'b0, '0);
    add_row({MODE_ENQ, 16'h1234, 8'haa, 16'h7fff}, 1, 1'b1,
            {ST_FULL, 16'h0000, 8'h00, 16'h0000, 5'(CAP)});
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b0, '0);
    add_row({MODE_ENQ, 16'ha5a5, 8'h5a, 16'h7fff}, 1, 1'b0, '0);
    add_row({MODE_ENQ, 16'hffff, 8'hff, 16'h7fff}, 1, 1'b1,
            {ST_FULL, 16'h0000, 8'h00, 16'h0000, 5'(CAP)});
    // drain completely, then one more dequeue on empty
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, CAP, 1'b0, '0);
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b1,
            {ST_EMPTY, 16'h0000, 8'h00, 16'h0000, 5'd0});
    add_row({MODE_ENQ, 16'h8001, 8'h80, 16'h8000}, 1, 1'b1,
            {ST_ENQUEUED, 16'h0000, 8'h00, 16'h0000, 5'd1});
    add_row({MODE_DEQ, 16'h0000, 8'h00, 16'h0000}, 1, 1'b1,
            {ST_DEQUEUED, 16'h8001, 8'h80, 16'h8000, 5'd0});

    // synchronous reset, released once and never asserted again
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (drill_rows[r]) begin
      for (k = 0; k < drill_rows[r].reps; k++) begin
        it = drill_rows[r].item;
        it.tag_in = drill_rows[r].item.tag_in + 16'(k);
        send_item(it, drill_rows[r].pinned, drill_rows[r].result);
      end
    end

    // random part: the enqueue share shifts every 64 items so the queue
    // swings between empty, half full and full; priorities lean toward a
    // narrow range so ties are common
    enq_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(3))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          2:       enq_pct = 70;
          default: enq_pct = 92;
        endcase
        gaps_on = $urandom_range(2) != 0;
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS)
        gaps_on = 1'b0;
      it.mode   = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      it.tag_in = 16'($urandom);
      it.age_in = 8'($urandom);
      occ_tie   = $urandom_range(3);
      case (occ_tie)
        0: it.priority_in = 16'($urandom_range(0, 6) - 3);
        1: begin
          case ($urandom_range(3))
            0:       it.priority_in = 16'h7fff;
            1:       it.priority_in = 16'h8000;
            2:       it.priority_in = 16'h0000;
            default: it.priority_in = 16'hffff;
          endcase
        end
        default: it.priority_in = 16'($urandom);
      endcase
      send_item(it, 1'b0, '0);
    end

    // wait out the last results, then idle a while for anything stray
    start     <= 1'b0;
    pin_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items in %0d cycles: %0d stored, %0d served, %0d on empty, %0d dropped",
             items_taken, cycle_count, n_enqueued, n_dequeued, n_empty, n_full);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
